// ===== rtl/core/fexp_pkg.sv =====
// shared constants for the single-precision exponential pipeline
package fexp_pkg;

    // pipeline depth of one fused multiply-add cell
    localparam int FMA_LAT = 4;

    localparam logic [31:0] F_CLAMP_HI  = 32'h42B0C0A5;
    localparam logic [31:0] F_CLAMP_LO  = 32'hC2B0C0A5;
    localparam logic [31:0] F_LOG2E     = 32'h3FB8AA3B;
    localparam logic [31:0] F_LN2_HI    = 32'h3F318000;
    localparam logic [31:0] F_LN2_LO    = 32'hB95E8083;
    localparam logic [31:0] F_PC0       = 32'h39506967;
    localparam logic [31:0] F_PC1       = 32'h3AB743CE;
    localparam logic [31:0] F_PC2       = 32'h3C088908;
    localparam logic [31:0] F_PC3       = 32'h3D2AA9C1;
    localparam logic [31:0] F_PC4       = 32'h3E2AAAAA;
    localparam logic [31:0] F_HALF      = 32'h3F000000;
    localparam logic [31:0] F_ONE       = 32'h3F800000;
    localparam logic [31:0] F_NEG_ZERO  = 32'h80000000;
    localparam logic [31:0] F_QNAN      = 32'h7FC00000;
    localparam logic [8:0]  EXP_BIAS    = 9'h07F;

endpackage

// ===== rtl/core/fexp_delay.sv =====
// shift line of registers that carries an operand alongside the arithmetic cells
module fexp_delay #(
    parameter int W = 32,
    parameter int D = 1
) (
    input  logic         i_clk,
    input  logic [W-1:0] i_d,
    output logic [W-1:0] o_q
);

    logic [W-1:0] r_tap [D];

    always_ff @(posedge i_clk) begin
        r_tap[0] <= i_d;
        for (int i = 1; i < D; i++) begin
            r_tap[i] <= r_tap[i-1];
        end
    end

    assign o_q = r_tap[D-1];

endmodule

// ===== rtl/core/fexp_fma.sv =====
// four-stage fused multiply-add cell, round to nearest even, subnormals kept
module fexp_fma
    import fexp_pkg::*;
(
    input  logic        i_clk,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    input  logic [31:0] i_c,
    output logic [31:0] o_y
);

    // right shift that folds every lost bit into one sticky bit
    function automatic logic [77:0] shr_sticky(input logic [76:0] v, input logic [11:0] amt);
        logic [76:0] mask;
        logic [76:0] res;
        logic        lost;
        if (amt >= 12'd77) begin
            res  = '0;
            lost = |v;
        end else begin
            mask = (77'(1) << amt) - 77'(1);
            res  = v >> amt;
            lost = |(v & mask);
        end
        return {res, lost};
    endfunction

    // stage 1: unpack and multiply
    logic [7:0]  w_ea, w_eb, w_ec;
    logic [23:0] w_ma, w_mb, w_mc;
    logic        w_sp, w_sc;
    logic        w_anan, w_bnan, w_cnan, w_ainf, w_binf, w_cinf, w_pinf;

    assign w_ea = (i_a[30:23] == 8'd0) ? 8'd1 : i_a[30:23];
    assign w_eb = (i_b[30:23] == 8'd0) ? 8'd1 : i_b[30:23];
    assign w_ec = (i_c[30:23] == 8'd0) ? 8'd1 : i_c[30:23];
    assign w_ma = {i_a[30:23] != 8'd0, i_a[22:0]};
    assign w_mb = {i_b[30:23] != 8'd0, i_b[22:0]};
    assign w_mc = {i_c[30:23] != 8'd0, i_c[22:0]};
    assign w_sp = i_a[31] ^ i_b[31];
    assign w_sc = i_c[31];
    assign w_anan = (i_a[30:23] == 8'hFF) && (i_a[22:0] != 23'd0);
    assign w_bnan = (i_b[30:23] == 8'hFF) && (i_b[22:0] != 23'd0);
    assign w_cnan = (i_c[30:23] == 8'hFF) && (i_c[22:0] != 23'd0);
    assign w_ainf = (i_a[30:0] == 31'h7F800000);
    assign w_binf = (i_b[30:0] == 31'h7F800000);
    assign w_cinf = (i_c[30:0] == 31'h7F800000);
    assign w_pinf = w_ainf | w_binf;

    logic [47:0] r1_p;
    logic [10:0] r1_topp, r1_topc;
    logic [23:0] r1_mc;
    logic        r1_sp, r1_sc, r1_pz, r1_cz, r1_nan, r1_inf, r1_infs;

    always_ff @(posedge i_clk) begin
        r1_p    <= w_ma * w_mb;
        r1_topp <= 11'({3'b0, w_ea}) + 11'({3'b0, w_eb}) - 11'd253;
        r1_topc <= 11'({3'b0, w_ec}) - 11'd127;
        r1_mc   <= w_mc;
        r1_sp   <= w_sp;
        r1_sc   <= w_sc;
        r1_pz   <= (w_ma == 24'd0) || (w_mb == 24'd0);
        r1_cz   <= (w_mc == 24'd0);
        r1_nan  <= w_anan | w_bnan | w_cnan
                 | (w_ainf & (w_mb == 24'd0)) | (w_binf & (w_ma == 24'd0))
                 | (w_pinf & w_cinf & (w_sp != w_sc));
        r1_inf  <= w_pinf | w_cinf;
        r1_infs <= w_pinf ? w_sp : w_sc;
    end

    // stage 2: align the smaller operand and add
    logic [10:0] w_d, w_amt, w_top;
    logic        w_pdom, w_sbig, w_ssm, w_neg, w_sign;
    logic [75:0] w_big, w_small, w_aln;
    logic [77:0] w_shr, w_sum;
    logic [76:0] w_mag;

    always_comb begin
        w_d    = r1_topp - r1_topc;
        w_pdom = r1_cz | (!r1_pz & !w_d[10]);
        if (w_pdom) begin
            w_big   = {r1_p, 28'd0};
            w_sbig  = r1_sp;
            w_small = r1_cz ? 76'd0 : {r1_mc, 52'd0};
            w_ssm   = r1_sc;
            w_amt   = w_d;
            w_top   = r1_topp;
        end else begin
            w_big   = {r1_mc, 52'd0};
            w_sbig  = r1_sc;
            w_small = {r1_p, 28'd0};
            w_ssm   = r1_sp;
            w_amt   = 11'd0 - w_d;
            w_top   = r1_topc;
        end
        w_shr = shr_sticky({1'b0, w_small}, {1'b0, w_amt});
        w_aln = w_shr[76:1] | {75'd0, w_shr[0]};
        if (w_sbig == w_ssm) begin
            w_sum  = {2'b0, w_big} + {2'b0, w_aln};
            w_neg  = 1'b0;
            w_mag  = w_sum[76:0];
            w_sign = w_sbig;
        end else begin
            w_sum  = {2'b0, w_big} - {2'b0, w_aln};
            w_neg  = w_sum[77];
            w_mag  = w_neg ? 77'(78'd0 - w_sum) : w_sum[76:0];
            w_sign = w_neg ? w_ssm : w_sbig;
        end
        // exact cancellation gives +0 unless both addends carry the minus sign
        if (w_mag == 77'd0) begin
            w_sign = (r1_sp == r1_sc) ? r1_sp : 1'b0;
        end
    end

    logic [76:0] r2_mag;
    logic [10:0] r2_top;
    logic        r2_sign, r2_nan, r2_inf, r2_infs;

    always_ff @(posedge i_clk) begin
        r2_mag  <= w_mag;
        r2_top  <= w_top;
        r2_sign <= w_sign;
        r2_nan  <= r1_nan;
        r2_inf  <= r1_inf;
        r2_infs <= r1_infs;
    end

    // stage 3: leading one search and normalizing shift
    logic [6:0]  w_lead;
    logic [11:0] w_be, w_ssub, w_ramt;
    logic [9:0]  w_ebase;
    logic [76:0] w_norm;
    logic        w_st;
    logic [77:0] w_rsh;

    always_comb begin
        w_lead = 7'd0;
        for (int i = 0; i < 77; i++) begin
            if (r2_mag[i]) begin
                w_lead = 7'(i);
            end
        end
        w_be   = {r2_top[10], r2_top} + {5'd0, w_lead} + 12'd52;
        w_ssub = {r2_top[10], r2_top} + 12'd127;
        w_ramt = 12'd0 - w_ssub;
        w_rsh  = shr_sticky(r2_mag, w_ramt);
        if (!w_be[11] && (w_be != 12'd0)) begin
            w_norm  = r2_mag << (7'd76 - w_lead);
            w_st    = 1'b0;
            w_ebase = 10'(w_be - 12'd1);
        end else if (!w_ssub[11]) begin
            // result falls in the subnormal range
            w_norm  = r2_mag << w_ssub[6:0];
            w_st    = 1'b0;
            w_ebase = 10'd0;
        end else begin
            w_norm  = w_rsh[77:1];
            w_st    = w_rsh[0];
            w_ebase = 10'd0;
        end
    end

    logic [76:0] r3_norm;
    logic [9:0]  r3_ebase;
    logic        r3_st, r3_zero, r3_sign, r3_nan, r3_inf, r3_infs;

    always_ff @(posedge i_clk) begin
        r3_norm  <= w_norm;
        r3_ebase <= w_ebase;
        r3_st    <= w_st;
        r3_zero  <= (r2_mag == 77'd0);
        r3_sign  <= r2_sign;
        r3_nan   <= r2_nan;
        r3_inf   <= r2_inf;
        r3_infs  <= r2_infs;
    end

    // stage 4: round and pack
    logic [23:0] w_mant;
    logic        w_rnd, w_stk, w_inc;
    logic [33:0] w_pack;
    logic [31:0] w_res;

    always_comb begin
        w_mant = r3_norm[76:53];
        w_rnd  = r3_norm[52];
        w_stk  = (|r3_norm[51:0]) | r3_st;
        w_inc  = w_rnd & (w_stk | w_mant[0]);
        w_pack = {1'b0, r3_ebase, 23'd0} + {10'd0, w_mant} + {33'd0, w_inc};
        if (r3_nan) begin
            w_res = F_QNAN;
        end else if (r3_inf) begin
            w_res = {r3_infs, 31'h7F800000};
        end else if (r3_zero) begin
            w_res = {r3_sign, 31'd0};
        end else if (w_pack >= 34'h07F800000) begin
            w_res = {r3_sign, 31'h7F800000};
        end else begin
            w_res = {r3_sign, w_pack[30:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        o_y <= w_res;
    end

endmodule

// ===== rtl/core/float32_exp_approximation_top.sv =====
// single-precision exponential: clamp, range reduction, polynomial and scaling
// throughput: one transfer per cycle, set by the chain of four-stage fma cells
// busy stays low; the receiver cannot stall, each result shows for one cycle
// reset clears only the valid pipeline; data registers load freely
module float32_exp_approximation_top
    import fexp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    input  logic [31:0] i_x_bits,
    output logic        busy,
    output logic        o_strobe,
    output logic [31:0] o_y_bits
);

    localparam int VLEN = 12 * FMA_LAT + 2;

    function automatic logic [31:0] ord_key(input logic [31:0] f);
        return f[31] ? ~f : {1'b1, f[30:0]};
    endfunction

    function automatic logic [31:0] clamp(input logic [31:0] f);
        logic [31:0] t;
        t = f;
        if (((f[30:23] == 8'hFF) && (f[22:0] != 23'd0)) ||
            !(ord_key(f) < ord_key(F_CLAMP_HI))) begin
            t = F_CLAMP_HI;
        end
        if (!(ord_key(t) > ord_key(F_CLAMP_LO))) begin
            t = F_CLAMP_LO;
        end
        return t;
    endfunction

    function automatic logic [31:0] int_to_f(input logic [9:0] n);
        logic [9:0]  m;
        logic [3:0]  k;
        logic [31:0] w;
        logic [22:0] fr;
        m = n[9] ? (10'd0 - n) : n;
        k = 4'd0;
        for (int i = 0; i < 10; i++) begin
            if (m[i]) begin
                k = 4'(i);
            end
        end
        fr = 23'({13'd0, m} << (5'd23 - {1'b0, k}));
        w  = {n[9], 8'd127 + {4'd0, k}, fr};
        return (m == 10'd0) ? 32'd0 : w;
    endfunction

    logic [VLEN-1:0] r_vld;
    logic            w_accept;

    assign busy     = 1'b0;
    assign w_accept = start & !busy;
    assign o_strobe = r_vld[VLEN-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[VLEN-2:0], w_accept};
        end
    end

    logic [31:0] r_x;

    always_ff @(posedge i_clk) begin
        r_x <= clamp(i_x_bits);
    end

    // n = floor(x*log2e + 0.5)
    logic [31:0] w_fx;

    fexp_fma u_fx (.i_clk(i_clk), .i_a(r_x), .i_b(F_LOG2E), .i_c(F_HALF), .o_y(w_fx));

    logic [7:0]  w_fe;
    logic [23:0] w_fm, w_fmask, w_fint;
    logic [4:0]  w_fsh;
    logic [9:0]  w_n;

    always_comb begin
        w_fe    = w_fx[30:23];
        w_fm    = {1'b1, w_fx[22:0]};
        w_fsh   = 5'(8'd150 - w_fe);
        w_fmask = (24'd1 << w_fsh) - 24'd1;
        w_fint  = w_fm >> w_fsh;
        if (w_fe < 8'd127) begin
            w_n = (w_fx[31] && (w_fx[30:0] != 31'd0)) ? 10'h3FF : 10'd0;
        end else if (w_fx[31]) begin
            w_n = 10'd0 - (10'(w_fint) + {9'd0, |(w_fm & w_fmask)});
        end else begin
            w_n = 10'(w_fint);
        end
    end

    logic [31:0] r_nf;
    logic [8:0]  r_sc;

    always_ff @(posedge i_clk) begin
        r_nf <= int_to_f(w_n);
        r_sc <= 9'(w_n) + EXP_BIAS;
    end

    // range reduction
    logic [31:0] w_tmp, w_z, w_xd, w_zd, w_x1, w_x2;

    fexp_fma u_tmp (.i_clk(i_clk), .i_a(r_nf), .i_b(F_LN2_HI), .i_c(F_NEG_ZERO), .o_y(w_tmp));
    fexp_fma u_z   (.i_clk(i_clk), .i_a(r_nf), .i_b(F_LN2_LO), .i_c(F_NEG_ZERO), .o_y(w_z));

    fexp_delay #(.W(32), .D(2 * FMA_LAT + 1)) u_xdly (.i_clk(i_clk), .i_d(r_x), .o_q(w_xd));
    fexp_delay #(.W(32), .D(FMA_LAT))         u_zdly (.i_clk(i_clk), .i_d(w_z), .o_q(w_zd));

    fexp_fma u_x1 (.i_clk(i_clk), .i_a(w_xd), .i_b(F_ONE),
                   .i_c({~w_tmp[31], w_tmp[30:0]}), .o_y(w_x1));
    fexp_fma u_x2 (.i_clk(i_clk), .i_a(w_x1), .i_b(F_ONE),
                   .i_c({~w_zd[31], w_zd[30:0]}), .o_y(w_x2));

    // polynomial, the reduced value travels beside it
    logic [31:0] w_r [6];
    logic [31:0] w_zz, w_zzd, w_y0, w_y1, w_y2, w_y3, w_y4, w_y5, w_y6;
    logic [8:0]  w_scd;

    assign w_r[0] = w_x2;

    for (genvar g = 1; g < 6; g++) begin : g_rline
        fexp_delay #(.W(32), .D(FMA_LAT)) u_rdly (.i_clk(i_clk), .i_d(w_r[g-1]), .o_q(w_r[g]));
    end

    fexp_fma u_zz (.i_clk(i_clk), .i_a(w_x2), .i_b(w_x2), .i_c(F_NEG_ZERO), .o_y(w_zz));
    fexp_fma u_y0 (.i_clk(i_clk), .i_a(F_PC0), .i_b(w_x2), .i_c(F_PC1), .o_y(w_y0));
    fexp_fma u_y1 (.i_clk(i_clk), .i_a(w_y0), .i_b(w_r[1]), .i_c(F_PC2), .o_y(w_y1));
    fexp_fma u_y2 (.i_clk(i_clk), .i_a(w_y1), .i_b(w_r[2]), .i_c(F_PC3), .o_y(w_y2));
    fexp_fma u_y3 (.i_clk(i_clk), .i_a(w_y2), .i_b(w_r[3]), .i_c(F_PC4), .o_y(w_y3));
    fexp_fma u_y4 (.i_clk(i_clk), .i_a(w_y3), .i_b(w_r[4]), .i_c(F_HALF), .o_y(w_y4));

    fexp_delay #(.W(32), .D(4 * FMA_LAT)) u_zzdly (.i_clk(i_clk), .i_d(w_zz), .o_q(w_zzd));

    fexp_fma u_y5 (.i_clk(i_clk), .i_a(w_y4), .i_b(w_zzd), .i_c(w_r[5]), .o_y(w_y5));
    fexp_fma u_y6 (.i_clk(i_clk), .i_a(w_y5), .i_b(F_ONE), .i_c(F_ONE), .o_y(w_y6));

    // scale by 2^n
    fexp_delay #(.W(9), .D(10 * FMA_LAT)) u_scdly (.i_clk(i_clk), .i_d(r_sc), .o_q(w_scd));

    fexp_fma u_out (.i_clk(i_clk), .i_a(w_y6), .i_b({w_scd, 23'd0}), .i_c(F_NEG_ZERO),
                    .o_y(o_y_bits));

endmodule

// ===== tb/sv/float32_exp_approximation_top_tb.sv =====
// testbench for the single-precision exponential: bit-exact predictor and result checker
module float32_exp_approximation_top_tb
    import fexp_pkg::*;
();

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 120;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic [31:0] i_x_bits;
    logic        busy;
    logic        o_strobe;
    logic [31:0] o_y_bits;

    logic [31:0] expected_y[$];
    int          error_count;
    int          idle_cycles;

    float32_exp_approximation_top u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_x_bits (i_x_bits),
        .busy     (busy),
        .o_strobe (o_strobe),
        .o_y_bits (o_y_bits)
    );

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    // float32 pattern to exact double value
    function automatic real fp_widen(input logic [31:0] f);
        real v;
        if (f[30:23] == 8'hff) begin
            return $bitstoreal({f[31], 11'h7ff, f[22:0], 29'b0});
        end
        if (f[30:23] == 8'h00) begin
            v = real'(f[22:0]) * $bitstoreal({1'b0, 11'(1023 - 149), 52'b0});
            return f[31] ? -v : v;
        end
        return $bitstoreal({f[31], 11'(f[30:23]) + 11'd896, f[22:0], 29'b0});
    endfunction

    // double to float32, round to nearest even, subnormals kept
    function automatic logic [31:0] fp_round_dbl(input real d);
        logic [63:0]     b;
        longint unsigned sig;
        longint unsigned rem;
        longint unsigned half;
        longint unsigned r;
        int              fe;
        int              sh;
        b = $realtobits(d);
        if (b[62:52] == 11'h7ff) begin
            if (b[51:0] != 0) return {b[63], 8'hff, 1'b1, b[50:29]};
            return {b[63], 8'hff, 23'b0};
        end
        if (b[62:52] == 11'h000) return {b[63], 31'b0};
        fe = int'(b[62:52]) - 896;
        if (fe >= 255) return {b[63], 8'hff, 23'b0};
        sig = {12'b1, b[51:0]};
        if (fe >= 1) begin
            sh = 29;
            r  = (longint'(fe) << 23) | ((sig >> 29) & 64'h7fffff);
        end else begin
            sh = 30 - fe;
            if (sh > 60) return {b[63], 31'b0};
            r = sig >> sh;
        end
        rem  = sig & ((64'd1 << sh) - 1);
        half = 64'd1 << (sh - 1);
        if (rem > half || (rem == half && r[0])) r++;
        return {b[63], r[30:0]};
    endfunction

    function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
        return fp_round_dbl(fp_widen(a) * fp_widen(b));
    endfunction

    function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b);
        return fp_round_dbl(fp_widen(a) + fp_widen(b));
    endfunction

    function automatic logic [31:0] fp_sub(input logic [31:0] a, input logic [31:0] b);
        return fp_round_dbl(fp_widen(a) - fp_widen(b));
    endfunction

    // fused a*b+c: exact product, sum error breaks false ties of the double rounding
    function automatic logic [31:0] fp_fma(input logic [31:0] a, input logic [31:0] b,
                                           input logic [31:0] c);
        real         p;
        real         cd;
        real         s;
        real         bv;
        real         err;
        logic [63:0] u;
        p   = fp_widen(a) * fp_widen(b);
        cd  = fp_widen(c);
        s   = p + cd;
        bv  = s - p;
        err = (p - (s - bv)) + (cd - bv);
        u   = $realtobits(s);
        if (err != 0.0 && u[62:52] >= 11'd897 && u[62:52] != 11'h7ff &&
            u[28:0] == 29'h10000000) begin
            if ((err < 0.0) == u[63]) u++;
            else u--;
            s = $bitstoreal(u);
        end
        return fp_round_dbl(s);
    endfunction

    function automatic logic [31:0] predict_exp(input logic [31:0] x_in);
        logic [31:0] xv;
        logic [31:0] fx;
        logic [31:0] tmp;
        logic [31:0] z;
        logic [31:0] y;
        logic [31:0] scale;
        real         fxr;
        int          n;
        xv = x_in;
        // nan falls through both compares onto the upper limit
        if (xv[30:23] == 8'hff && xv[22:0] != 0) xv = F_CLAMP_HI;
        if (!(fp_widen(xv) < fp_widen(F_CLAMP_HI))) xv = F_CLAMP_HI;
        if (!(fp_widen(xv) > fp_widen(F_CLAMP_LO))) xv = F_CLAMP_LO;
        fx  = fp_fma(xv, F_LOG2E, F_HALF);
        fxr = fp_widen(fx);
        n   = $rtoi(fxr);
        if (real'(n) > fxr) n = n - 1;
        fx  = fp_round_dbl(real'(n));
        tmp = fp_mul(fx, F_LN2_HI);
        z   = fp_mul(fx, F_LN2_LO);
        xv  = fp_sub(xv, tmp);
        xv  = fp_sub(xv, z);
        z   = fp_mul(xv, xv);
        y   = F_PC0;
        y   = fp_fma(y, xv, F_PC1);
        y   = fp_fma(y, xv, F_PC2);
        y   = fp_fma(y, xv, F_PC3);
        y   = fp_fma(y, xv, F_PC4);
        y   = fp_fma(y, xv, F_HALF);
        y   = fp_fma(y, z, xv);
        y   = fp_add(y, F_ONE);
        scale = 32'(n + 32'(EXP_BIAS)) << 23;
        return fp_mul(y, scale);
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        $display("mismatch: %s expected %08h got %08h at %0t", what, want, got, $time);
        error_count++;
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // one transfer, then an optional idle gap with start low
    task automatic send_x(input logic [31:0] x, input int gap);
        @(negedge i_clk);
        start    <= 1'b1;
        i_x_bits <= x;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        expected_y.push_back(predict_exp(x));
        if (gap > 0) begin
            @(negedge i_clk);
            start    <= 1'b0;
            i_x_bits <= $urandom;
            repeat (gap - 1) @(posedge i_clk);
        end
    endtask

    function automatic logic [31:0] random_x();
        int k;
        k = $urandom_range(0, 99);
        if (k < 30) return $urandom;
        // moderate magnitudes, the bulk of the useful range
        if (k < 75) return {1'($urandom), 8'($urandom_range(110, 133)), 23'($urandom)};
        // around the clamp limits and the zero-scale corner
        if (k < 85) return {1'($urandom), 8'd133, 7'h30, 16'($urandom)};
        if (k < 92) return {1'($urandom), 8'h00, 23'($urandom)};
        if (k < 96) return {1'($urandom), 8'hff, 23'($urandom)};
        return {1'($urandom), 8'($urandom_range(134, 254)), 23'($urandom)};
    endfunction

    task automatic test_special_values();
        logic [31:0] vals[$];
        vals = '{32'h00000000, 32'h80000000, 32'h3f800000, 32'hbf800000,
                 32'h7f800000, 32'hff800000, 32'h7fc00000, 32'h7f800001,
                 32'hffc00000, 32'h7f7fffff, 32'hff7fffff, 32'h00000001,
                 32'h80000001, 32'h007fffff, 32'h807fffff, F_CLAMP_HI,
                 F_CLAMP_LO, 32'h42b0c0a6, 32'hc2b0c0a6, 32'hc2af0000,
                 32'h3f000000, 32'hbf000000, 32'h42b00000, 32'hc2ae0000,
                 32'hffffffff};
        foreach (vals[i]) send_x(vals[i], (i % 3 == 0) ? 0 : pick_gap());
    endtask

    task automatic test_random_values();
        for (int i = 0; i < 2000; i++) begin
            // stretches with no gaps at all
            send_x(random_x(), (i % 400 < 100) ? 0 : pick_gap());
            if (i == 1000) begin
                // hold off until the pipeline has drained
                @(negedge i_clk);
                start <= 1'b0;
                while (expected_y.size() != 0) @(posedge i_clk);
            end
        end
        @(negedge i_clk);
        start <= 1'b0;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            if (expected_y.size() == 0) begin
                report_mismatch("unexpected result", 32'h0, o_y_bits);
            end else begin
                if (o_y_bits !== expected_y[0])
                    report_mismatch("y_bits", expected_y[0], o_y_bits);
                void'(expected_y.pop_front());
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
                $display("** float32_exp_approximation_top: FAILED **");
                $finish;
            end
        end
    end

    initial begin
        error_count = 0;
        idle_cycles = 0;
        i_rst_n  = 1'b0;
        start    = 1'b0;
        i_x_bits = 32'h0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_special_values();
        test_random_values();
        while (expected_y.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0 && expected_y.size() == 0) begin
            $display("** float32_exp_approximation_top: PASSED **");
        end else begin
            $display("** float32_exp_approximation_top: FAILED **");
        end
        $finish;
    end

endmodule
